/* rtl/mma_pkg.sv */
// Shared constants, codes and types of the matrix multiply-accumulate block.
`default_nettype none

package mma_pkg;

  localparam int DEFAULT_MAX_DIM = 16;

  localparam int OP_W      = 3;
  localparam int IDX_W     = 4;
  localparam int VALUE_W   = 48;
  localparam int ELEM_W    = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * ELEM_W;
  // 48-bit C plus up to 64 products of magnitude 2^30 stays below 2^49
  localparam int SUM_W     = VALUE_W + 2;

  localparam logic [OP_W-1:0] OP_WRITE_A = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_C = 3'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_C  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_USED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USED  = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

endpackage

`default_nettype wire

/* rtl/mma_if.sv */
// Item channel interfaces: input items and result items.
`default_nettype none

interface mma_in_if import mma_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [IDX_W-1:0]       row_index;
  logic [IDX_W-1:0]       col_index;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, row_index, col_index, value, input ready);
  modport sink   (input valid, operation, row_index, col_index, value, output ready);
endinterface

interface mma_out_if import mma_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic                      status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

`default_nettype wire

/* rtl/mma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mma_ram import mma_pkg::*; #(
  parameter int WIDTH = ELEM_W,
  parameter int DEPTH = DEFAULT_MAX_DIM * DEFAULT_MAX_DIM,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/mma_mac.sv */
// Shared multiply-accumulate unit: registered product, exact sum, 48-bit saturation.
`default_nettype none

module mma_mac import mma_pkg::*; (
  input  wire logic      clk,
  input  wire mac_ctrl_t ctrl,
  input  wire elem_t     a,
  input  wire elem_t     b,
  input  wire value_t    c,
  output value_t         sum_sat
);

  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  acc;
  logic                     pos_ovf;
  logic                     neg_ovf;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= a * b;
    end
    if (ctrl.acc_load) begin
      acc <= SUM_W'(c);
    end else if (ctrl.acc_add) begin
      acc <= acc + SUM_W'(prod);
    end
  end

  // bits above the 48-bit sign must all match the sign
  assign pos_ovf = !acc[SUM_W-1] && (|acc[SUM_W-2:VALUE_W-1]);
  assign neg_ovf = acc[SUM_W-1] && !(&acc[SUM_W-2:VALUE_W-1]);

  always_comb begin
    priority if (pos_ovf) begin
      sum_sat = {1'b0, {(VALUE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sum_sat = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sum_sat = acc[VALUE_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/matrix_multiply_accumulate.sv */
// Top level of the matrix multiply-accumulate block (C += A * B).
`default_nettype none

// Element writes of A, B or C are done as the item is taken; a read of C
// passes through a read state before its reply is registered. While idle,
// the block takes the next item as soon as the result register is free or
// being drained. A compute item runs every C element inside the configured
// sizes through one shared multiply-accumulate unit, one product per cycle
// while A and B are read: K reads per element, a drain of the multiply and
// add stages and a write-back of the saturated sum into C. After reset a
// clearing pass zeroes C, one entry per cycle, before any item is taken.

module matrix_multiply_accumulate import mma_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  mma_in_if.sink                    in_item,
  mma_out_if.source                 out_item
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int EW    = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RDC  = 3'd2;
  localparam logic [2:0] ST_MAC  = 3'd3;
  localparam logic [2:0] ST_DRN1 = 3'd4;
  localparam logic [2:0] ST_DRN2 = 3'd5;
  localparam logic [2:0] ST_WB   = 3'd6;

  function automatic logic [EW-1:0] eff_size(input logic [CFG_W-1:0] r);
    if (r == '0) begin
      return EW'(1);
    end else if (32'(r) > 32'(MAX_DIM)) begin
      return EW'(MAX_DIM);
    end else begin
      return EW'(r);
    end
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  function automatic elem_t sat16(input value_t v);
    if (!v[VALUE_W-1] && (|v[VALUE_W-2:ELEM_W-1])) begin
      return {1'b0, {(ELEM_W-1){1'b1}}};
    end else if (v[VALUE_W-1] && !(&v[VALUE_W-2:ELEM_W-1])) begin
      return {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      return v[ELEM_W-1:0];
    end
  endfunction

  logic [2:0]       state;
  logic [CFG_W-1:0] rows_used;
  logic [CFG_W-1:0] inner_used;
  logic [CFG_W-1:0] cols_used;
  logic [EW-1:0]    m_eff;
  logic [EW-1:0]    k_eff;
  logic [EW-1:0]    n_eff;
  logic [EW-1:0]    lim_r;
  logic [EW-1:0]    lim_c;
  logic [CW-1:0]    row_i;
  logic [CW-1:0]    col_j;
  logic [CW-1:0]    inner_t;
  logic [AW-1:0]    clr_addr;
  logic             p1_valid;
  logic             p1_first;
  logic             p2_valid;
  logic             out_valid;
  value_t           out_read_value;
  logic             out_status;

  logic             accept;
  logic             in_range;
  logic             op_known;
  logic             last_t;
  logic             last_j;
  logic             last_i;
  logic [AW-1:0]    in_addr;
  logic [AW-1:0]    ij_addr;

  logic             a_wr_en;
  logic             b_wr_en;
  logic             ab_rd_en;
  elem_t            wr_elem;
  elem_t            a_rd_data;
  elem_t            b_rd_data;
  logic             c_wr_en;
  logic [AW-1:0]    c_wr_addr;
  value_t           c_wr_data;
  logic             c_rd_en;
  logic [AW-1:0]    c_rd_addr;
  value_t           c_rd_data;
  mac_ctrl_t        mac_ctrl;
  value_t           mac_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used  <= DIM_RESET;
      inner_used <= DIM_RESET;
      cols_used  <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS_USED:  rows_used  <= cfg_data;
        REG_INNER_USED: inner_used <= cfg_data;
        REG_COLS_USED:  cols_used  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m_eff = eff_size(rows_used);
  assign k_eff = eff_size(inner_used);
  assign n_eff = eff_size(cols_used);

  always_comb begin
    unique case (in_item.operation)
      OP_WRITE_A: begin
        lim_r = m_eff;
        lim_c = k_eff;
      end
      OP_WRITE_B: begin
        lim_r = k_eff;
        lim_c = n_eff;
      end
      default: begin
        lim_r = m_eff;
        lim_c = n_eff;
      end
    endcase
  end

  assign in_range = (32'(in_item.row_index) < 32'(lim_r)) &&
                    (32'(in_item.col_index) < 32'(lim_c));
  assign op_known = (in_item.operation == OP_WRITE_A) || (in_item.operation == OP_WRITE_B) ||
                    (in_item.operation == OP_WRITE_C) || (in_item.operation == OP_READ_C);

  assign in_item.ready = (state == ST_IDLE) && (!out_valid || out_item.ready);
  assign accept        = in_item.valid && in_item.ready;

  assign in_addr = addr_of(CW'(in_item.row_index), CW'(in_item.col_index));
  assign ij_addr = addr_of(row_i, col_j);

  assign last_t = (32'(inner_t) + 32'd1) == 32'(k_eff);
  assign last_j = (32'(col_j) + 32'd1) == 32'(n_eff);
  assign last_i = (32'(row_i) + 32'd1) == 32'(m_eff);

  // memory port steering
  assign wr_elem  = sat16(in_item.value);
  assign a_wr_en  = accept && (in_item.operation == OP_WRITE_A) && in_range;
  assign b_wr_en  = accept && (in_item.operation == OP_WRITE_B) && in_range;
  assign ab_rd_en = (state == ST_MAC);

  always_comb begin
    c_wr_en = (state == ST_CLR) || (state == ST_WB) ||
              (accept && (in_item.operation == OP_WRITE_C) && in_range);
    priority if (state == ST_CLR) begin
      c_wr_addr = clr_addr;
      c_wr_data = '0;
    end else if (state == ST_WB) begin
      c_wr_addr = ij_addr;
      c_wr_data = mac_sum;
    end else begin
      c_wr_addr = in_addr;
      c_wr_data = in_item.value;
    end
    c_rd_en   = (accept && (in_item.operation == OP_READ_C) && in_range) ||
                ((state == ST_MAC) && (inner_t == '0));
    c_rd_addr = (state == ST_MAC) ? ij_addr : in_addr;
  end

  mma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (in_addr),
    .wr_data (wr_elem),
    .rd_en   (ab_rd_en),
    .rd_addr (addr_of(row_i, inner_t)),
    .rd_data (a_rd_data)
  );

  mma_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (in_addr),
    .wr_data (wr_elem),
    .rd_en   (ab_rd_en),
    .rd_addr (addr_of(inner_t, col_j)),
    .rd_data (b_rd_data)
  );

  mma_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_c_ram (
    .clk     (clk),
    .wr_en   (c_wr_en),
    .wr_addr (c_wr_addr),
    .wr_data (c_wr_data),
    .rd_en   (c_rd_en),
    .rd_addr (c_rd_addr),
    .rd_data (c_rd_data)
  );

  // the accumulator is loaded with C as the first product's operands arrive; every product then adds in
  assign mac_ctrl.mul_en   = p1_valid;
  assign mac_ctrl.acc_load = p1_first;
  assign mac_ctrl.acc_add  = p2_valid;

  mma_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .a       (a_rd_data),
    .b       (b_rd_data),
    .c       (c_rd_data),
    .sum_sat (mac_sum)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_addr  <= '0;
      row_i     <= '0;
      col_j     <= '0;
      inner_t   <= '0;
      p1_valid  <= 1'b0;
      p1_first  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid <= (state == ST_MAC);
      p1_first <= (state == ST_MAC) && (inner_t == '0);
      p2_valid <= p1_valid;
      if (out_valid && out_item.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_item.operation == OP_COMPUTE) begin
              state   <= ST_MAC;
              row_i   <= '0;
              col_j   <= '0;
              inner_t <= '0;
            end else if ((in_item.operation == OP_READ_C) && in_range) begin
              state <= ST_RDC;
            end else begin
              out_valid      <= 1'b1;
              out_read_value <= '0;
              out_status     <= !(op_known && in_range);
            end
          end
        end
        ST_RDC: begin
          out_valid      <= 1'b1;
          out_read_value <= c_rd_data;
          out_status     <= 1'b0;
          state          <= ST_IDLE;
        end
        ST_MAC: begin
          inner_t <= inner_t + CW'(1);
          if (last_t) begin
            state <= ST_DRN1;
          end
        end
        ST_DRN1: state <= ST_DRN2;
        ST_DRN2: state <= ST_WB;
        ST_WB: begin
          inner_t <= '0;
          state   <= ST_MAC;
          if (last_j) begin
            col_j <= '0;
            if (last_i) begin
              state          <= ST_IDLE;
              out_valid      <= 1'b1;
              out_read_value <= '0;
              out_status     <= 1'b0;
            end else begin
              row_i <= row_i + CW'(1);
            end
          end else begin
            col_j <= col_j + CW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_item.valid      = out_valid;
  assign out_item.read_value = out_read_value;
  assign out_item.status     = out_status;

  a_load_add_apart: assert property (@(posedge clk) disable iff (rst)
    !(p1_first && p2_valid))
    else $error("accumulator load collides with a pending add");

  a_rdc_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RDC) |-> !out_valid)
    else $error("C read completes while result register is occupied");

  a_compute_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_item.operation == OP_COMPUTE)) |=>
      ((state == ST_MAC) && (row_i == '0) && (col_j == '0) && (inner_t == '0)))
    else $error("compute did not start at the first element");

  a_pipe_in_compute: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> ((state == ST_MAC) || (state == ST_DRN1) || (state == ST_DRN2)))
    else $error("product pending outside the compute sequence");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for matrix_multiply_accumulate: directed table, then random phases.
`default_nettype none

module tb import mma_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM     = DEFAULT_MAX_DIM;
  localparam int ITEM_TARGET = 1700;
  localparam int STALL_LIMIT = 20000;
  localparam int DIRECTED_LEN = 24;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [OP_W-1:0] OP_NONE_LO = OP_READ_C + 1'b1;
  localparam logic [OP_W-1:0] OP_NONE_HI = '1;

  localparam value_t VAL_ZERO = '0;
  localparam value_t VAL_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VAL_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam elem_t  ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t  ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    value_t           value;
  } mma_item_t;

  typedef struct packed {
    value_t read_value;
    logic   status;
  } mma_reply_t;

  typedef enum logic {STEP_ITEM, STEP_SIZE} step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     reg_data;
    mma_item_t            item;
    logic                 typed;
    mma_reply_t           reply;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mma_in_if  in_ch ();
  mma_out_if out_ch ();

  matrix_multiply_accumulate #(.MAX_DIM(MAX_DIM)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirrored block state
  logic [CFG_W-1:0] rows_reg  = DIM_RESET;
  logic [CFG_W-1:0] inner_reg = DIM_RESET;
  logic [CFG_W-1:0] cols_reg  = DIM_RESET;
  elem_t  a_mem [MAX_DIM*MAX_DIM];
  elem_t  b_mem [MAX_DIM*MAX_DIM];
  value_t c_mem [MAX_DIM*MAX_DIM];
  bit     a_set [MAX_DIM*MAX_DIM];
  bit     b_set [MAX_DIM*MAX_DIM];

  mma_reply_t replies_due [$];
  int  mismatch_count = 0;
  int  useful_items = 0;
  bit  sender_quiet = 1'b0;
  step_t directed_steps [DIRECTED_LEN];

  function automatic int dim_of(logic [CFG_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  // Applies one item to the mirrored state and returns the reply it owes.
  function automatic mma_reply_t reply_for(mma_item_t it);
    mma_reply_t r;
    int m, k, n, lim_r, lim_c, slot;
    longint acc, wide;
    r.read_value = '0;
    r.status = STATUS_OK;
    m = dim_of(rows_reg);
    k = dim_of(inner_reg);
    n = dim_of(cols_reg);
    case (it.op)
      OP_COMPUTE: begin
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = longint'(c_mem[i*MAX_DIM+j]);
            for (int t = 0; t < k; t++)
              acc += longint'(a_mem[i*MAX_DIM+t]) * longint'(b_mem[t*MAX_DIM+j]);
            if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
            else if (acc < longint'(VAL_MIN)) acc = longint'(VAL_MIN);
            c_mem[i*MAX_DIM+j] = value_t'(acc);
          end
        end
      end
      OP_WRITE_A, OP_WRITE_B, OP_WRITE_C, OP_READ_C: begin
        lim_r = (it.op == OP_WRITE_B) ? k : m;
        lim_c = (it.op == OP_WRITE_A) ? k : n;
        if (int'(it.row) >= lim_r || int'(it.col) >= lim_c) begin
          r.status = STATUS_REJECT;
        end else begin
          slot = int'(it.row) * MAX_DIM + int'(it.col);
          wide = longint'(it.value);
          case (it.op)
            OP_WRITE_A: begin
              a_mem[slot] = (wide > longint'(ELEM_MAX)) ? ELEM_MAX :
                            (wide < longint'(ELEM_MIN)) ? ELEM_MIN : elem_t'(wide);
              a_set[slot] = 1'b1;
            end
            OP_WRITE_B: begin
              b_mem[slot] = (wide > longint'(ELEM_MAX)) ? ELEM_MAX :
                            (wide < longint'(ELEM_MIN)) ? ELEM_MIN : elem_t'(wide);
              b_set[slot] = 1'b1;
            end
            OP_WRITE_C: c_mem[slot] = it.value;
            default:    r.read_value = c_mem[slot];
          endcase
        end
      end
      default: r.status = STATUS_REJECT;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic value_t rand_value();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    case ($urandom_range(0, 7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3, 4: return value_t'(int'($urandom_range(0, 65535)) - 32768);
      5:       return value_t'(int'($urandom_range(0, 511)) - 256);
      default: return value_t'(wide[VALUE_W-1:0]);
    endcase
  endfunction

  // mostly small sizes; zero and oversize values exercise the clamp
  function automatic logic [CFG_W-1:0] pick_size();
    int r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 11) return CFG_W'(MAX_DIM);
    if (r < 15) return CFG_W'($urandom_range(MAX_DIM + 1, (1 << CFG_W) - 1));
    return CFG_W'($urandom_range(1, 4));
  endfunction

  function automatic step_t size_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    step_t s = '0;
    s.kind = STEP_SIZE;
    s.reg_index = idx;
    s.reg_data = data;
    return s;
  endfunction

  function automatic step_t item_step(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                      logic [IDX_W-1:0] col, value_t value);
    step_t s = '0;
    s.kind = STEP_ITEM;
    s.item = '{op: op, row: row, col: col, value: value};
    return s;
  endfunction

  function automatic step_t typed_step(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                                       logic [IDX_W-1:0] col, value_t value,
                                       value_t exp_value, logic exp_status);
    step_t s = item_step(op, row, col, value);
    s.typed = 1'b1;
    s.reply = '{read_value: exp_value, status: exp_status};
    return s;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_item(input mma_item_t it, input logic typed, input mma_reply_t typed_reply);
    mma_reply_t due;
    int gap;
    gap = sender_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.row_index <= it.row;
    in_ch.col_index <= it.col;
    in_ch.value     <= it.value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    due = reply_for(it);
    if (typed) due = typed_reply;
    if (due.status == STATUS_OK) useful_items++;
    replies_due.push_back(due);
  endtask

  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROWS_USED:  rows_reg  = data;
      REG_INNER_USED: inner_reg = data;
      REG_COLS_USED:  cols_reg  = data;
      default: ;
    endcase
  endtask

  // A compute may only touch operand entries that hold a written value.
  task automatic compute_when_loaded(input mma_item_t go);
    mma_item_t w;
    int m, k, n;
    m = dim_of(rows_reg);
    k = dim_of(inner_reg);
    n = dim_of(cols_reg);
    for (int i = 0; i < m; i++) begin
      for (int t = 0; t < k; t++) begin
        if (!a_set[i*MAX_DIM+t]) begin
          w = '{op: OP_WRITE_A, row: IDX_W'(i), col: IDX_W'(t), value: rand_value()};
          send_item(w, 1'b0, '0);
        end
      end
    end
    for (int t = 0; t < k; t++) begin
      for (int j = 0; j < n; j++) begin
        if (!b_set[t*MAX_DIM+j]) begin
          w = '{op: OP_WRITE_B, row: IDX_W'(t), col: IDX_W'(j), value: rand_value()};
          send_item(w, 1'b0, '0);
        end
      end
    end
    go.op = OP_COMPUTE;
    send_item(go, 1'b0, '0);
  endtask

  // reply checker and receiver-side stalls
  initial begin
    int stall_left;
    int beat;
    int replies_seen;
    mma_reply_t want;
    stall_left = 0;
    beat = 0;
    replies_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        beat++;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
          if (replies_due.size() == 0) begin
            flag_mismatch("reply with no item outstanding");
          end else begin
            want = replies_due.pop_front();
            if (out_ch.read_value !== want.read_value)
              flag_mismatch($sformatf("reply %0d read_value %h, expected %h",
                                      replies_seen, out_ch.read_value, want.read_value));
            if (out_ch.status !== want.status)
              flag_mismatch($sformatf("reply %0d status %b, expected %b",
                                      replies_seen, out_ch.status, want.status));
          end
          replies_seen++;
          // long hold-off so the block backs up and stalls its input
          if (replies_seen % 600 == 250) stall_left = 400;
        end
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          out_ch.ready <= 1'b1;
          if ((beat / 500) % 3 != 1) stall_left = gap_len();
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mma_item_t it;
    int m, k, n, steps, phase, pick, reads;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= '0;
    in_ch.row_index <= '0;
    in_ch.col_index <= '0;
    in_ch.value     <= '0;
    cfg_write       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    for (int s = 0; s < MAX_DIM*MAX_DIM; s++) begin
      a_mem[s] = '0;
      b_mem[s] = '0;
      c_mem[s] = '0;
      a_set[s] = 1'b0;
      b_set[s] = 1'b0;
    end

    directed_steps = '{
      typed_step(OP_READ_C,  4'd0,  4'd0,  VAL_ZERO, VAL_ZERO, STATUS_OK),
      typed_step(OP_READ_C,  4'd15, 4'd15, VAL_MAX,  VAL_ZERO, STATUS_OK),
      typed_step(OP_WRITE_C, 4'd15, 4'd15, VAL_MAX,  VAL_ZERO, STATUS_OK),
      typed_step(OP_READ_C,  4'd15, 4'd15, VAL_ZERO, VAL_MAX,  STATUS_OK),
      typed_step(OP_WRITE_C, 4'd0,  4'd0,  VAL_MIN,  VAL_ZERO, STATUS_OK),
      typed_step(OP_READ_C,  4'd0,  4'd0,  VAL_ZERO, VAL_MIN,  STATUS_OK),
      typed_step(OP_NONE_LO, 4'd15, 4'd15, VAL_MAX,  VAL_ZERO, STATUS_REJECT),
      typed_step(OP_NONE_HI, 4'd0,  4'd0,  VAL_MIN,  VAL_ZERO, STATUS_REJECT),
      size_step(REG_ROWS_USED,  5'd0),
      size_step(REG_INNER_USED, 5'd0),
      size_step(REG_COLS_USED,  5'd2),
      item_step(OP_WRITE_A, 4'd0, 4'd0, VAL_MIN),
      typed_step(OP_WRITE_A, 4'd0, 4'd1, VAL_ZERO, VAL_ZERO, STATUS_REJECT),
      item_step(OP_WRITE_B, 4'd0, 4'd0, VAL_MAX),
      item_step(OP_WRITE_B, 4'd0, 4'd1, -48'sd40000),
      item_step(OP_WRITE_C, 4'd0, 4'd1, VAL_MAX),
      // both C entries are driven past the 48-bit limits
      item_step(OP_COMPUTE, 4'd15, 4'd15, VAL_MIN),
      typed_step(OP_READ_C,  4'd0, 4'd0, VAL_ZERO, VAL_MIN,  STATUS_OK),
      typed_step(OP_READ_C,  4'd0, 4'd1, VAL_ZERO, VAL_MAX,  STATUS_OK),
      typed_step(OP_READ_C,  4'd1, 4'd0, VAL_ZERO, VAL_ZERO, STATUS_REJECT),
      typed_step(OP_READ_C,  4'd0, 4'd2, VAL_ZERO, VAL_ZERO, STATUS_REJECT),
      typed_step(OP_WRITE_B, 4'd1, 4'd0, VAL_ZERO, VAL_ZERO, STATUS_REJECT),
      size_step(REG_ROWS_USED, 5'd31),
      item_step(OP_READ_C, 4'd15, 4'd1, VAL_MAX)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int s = 0; s < DIRECTED_LEN; s++) begin
      if (directed_steps[s].kind == STEP_SIZE) begin
        drain_replies();
        write_size(directed_steps[s].reg_index, directed_steps[s].reg_data);
      end else begin
        send_item(directed_steps[s].item, directed_steps[s].typed, directed_steps[s].reply);
      end
    end

    phase = 0;
    while (useful_items < ITEM_TARGET) begin
      drain_replies();
      write_size(REG_ROWS_USED,  pick_size());
      write_size(REG_INNER_USED, pick_size());
      write_size(REG_COLS_USED,  pick_size());
      m = dim_of(rows_reg);
      k = dim_of(inner_reg);
      n = dim_of(cols_reg);
      sender_quiet = (phase % 4 == 1);
      steps = $urandom_range(15, 50);
      for (int s = 0; s < steps; s++) begin
        // sender stops until every owed reply is back
        if (phase % 5 == 3 && s == steps / 2) drain_replies();
        pick = $urandom_range(0, 99);
        it = '{op: OP_READ_C, row: '0, col: '0, value: rand_value()};
        if (pick < 25) begin
          it.op  = OP_WRITE_A;
          it.row = IDX_W'($urandom_range(0, m - 1));
          it.col = IDX_W'($urandom_range(0, k - 1));
        end else if (pick < 50) begin
          it.op  = OP_WRITE_B;
          it.row = IDX_W'($urandom_range(0, k - 1));
          it.col = IDX_W'($urandom_range(0, n - 1));
        end else if (pick < 78) begin
          it.op  = (pick < 58) ? OP_WRITE_C : OP_READ_C;
          it.row = IDX_W'($urandom_range(0, m - 1));
          it.col = IDX_W'($urandom_range(0, n - 1));
        end else if (pick < 84) begin
          it.op  = OP_COMPUTE;
          it.row = IDX_W'($urandom());
          it.col = IDX_W'($urandom());
        end else begin
          it.op  = OP_W'($urandom());
          it.row = IDX_W'($urandom());
          it.col = IDX_W'($urandom());
        end
        if (it.op == OP_COMPUTE) compute_when_loaded(it);
        else send_item(it, 1'b0, '0);
      end
      // close the phase with a multiply and a read-back of C
      it = '{op: OP_COMPUTE, row: IDX_W'($urandom()), col: IDX_W'($urandom()),
             value: rand_value()};
      compute_when_loaded(it);
      reads = (m * n < 12) ? m * n : 12;
      for (int s = 0; s < reads; s++) begin
        it = '{op: OP_READ_C, row: IDX_W'($urandom_range(0, m - 1)),
               col: IDX_W'($urandom_range(0, n - 1)), value: rand_value()};
        send_item(it, 1'b0, '0);
      end
      phase++;
    end

    drain_replies();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/mma_pkg.sv
rtl/mma_if.sv
rtl/mma_ram.sv
rtl/mma_mac.sv
rtl/matrix_multiply_accumulate.sv
verif/tb.sv
